### rtl/gsa_pkg.sv
// Shared types, constants and the free-slot search function of the slot allocator.
package gsa_pkg;

    localparam int SLOTS    = 256;
    localparam int GEN_BITS = 16;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int HW_W     = SLOT_W + 1;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // The free-slot search works on rows of GROUP bits.
    localparam int GROUP    = 16;
    localparam int GROUPS   = SLOTS / GROUP;
    localparam int GROUP_W  = $clog2(GROUP);
    localparam int GROUPS_W = $clog2(GROUPS);

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [GEN_BITS-1:0] gen_t;
    typedef logic [HW_W-1:0]     hw_t;
    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOTS-1:0]    slot_vec_t;

    localparam func_t FN_ALLOC  = func_t'(0);
    localparam func_t FN_FREE   = func_t'(1);
    localparam func_t FN_LOOKUP = func_t'(2);

    localparam status_t ST_OK    = status_t'(0);
    localparam status_t ST_FULL  = status_t'(1);
    localparam status_t ST_RANGE = status_t'(2);
    localparam status_t ST_STALE = status_t'(3);

    localparam gen_t GEN_ONE = gen_t'(1);
    localparam gen_t GEN_MAX = '1;

    // Index of the lowest set bit: first the lowest nonempty row, then the
    // lowest bit within that row. Returns zero when no bit is set.
    function automatic slot_t lowest_set(slot_vec_t v);
        logic [GROUPS-1:0]   any_row;
        logic [GROUPS_W-1:0] grp;
        logic [GROUP-1:0]    row;
        logic [GROUP_W-1:0]  bit_idx;
        any_row = '0;
        grp     = '0;
        bit_idx = '0;
        for (int i = 0; i < GROUPS; i++) begin
            any_row[i] = |v[i*GROUP +: GROUP];
        end
        for (int i = GROUPS - 1; i >= 0; i--) begin
            if (any_row[i]) begin
                grp = GROUPS_W'(i);
            end
        end
        row = v[grp*GROUP +: GROUP];
        for (int i = GROUP - 1; i >= 0; i--) begin
            if (row[i]) begin
                bit_idx = GROUP_W'(i);
            end
        end
        return {grp, bit_idx};
    endfunction

endpackage

### rtl/generational_slot_allocator.sv
// Top level of the generational slot allocator: handle checks, free bitmap and result register.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  request  | in_valid / in_ready  | func, slot, gen
//  result   | out_valid / out_ready| status, out_slot, out_gen, live_count
//
// One request is taken per cycle when the result side keeps up. A request is
// registered together with the generation RAM read of its slot, is executed
// in the execute stage and its result is then registered in the output
// register. The free-bitmap search for a request runs in the cycle that
// registers it, on the bitmap as the request then executing leaves it; the
// generation read-modify-write fits in the execute cycle.
// Reset clears the free bitmap and the free count and sets the never-used pointer
// to one at once; the generation RAM needs no clearing pass. A stalled result
// holds the execute stage, and the input stays ready as long as that stage can drain.
module generational_slot_allocator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gsa_pkg::func_t   func,
    input  gsa_pkg::slot_t   slot,
    input  gsa_pkg::gen_t    gen,
    output logic             out_valid,
    input  logic             out_ready,
    output gsa_pkg::status_t status,
    output gsa_pkg::slot_t   out_slot,
    output gsa_pkg::gen_t    out_gen,
    output gsa_pkg::slot_t   live_count
);

    import gsa_pkg::*;

    // Execute stage: the registered request and its RAM read.
    logic      s1_valid_reg;
    func_t     func_reg;
    slot_t     slot_reg;
    gen_t      gen_reg;
    slot_t     pick_reg;
    logic      byp_reg;
    gen_t      byp_data_reg;

    // Allocator state.
    slot_vec_t free_reg;
    slot_vec_t free_next;
    hw_t       hw_reg;
    hw_t       hw_next;
    slot_t     ft_reg;
    slot_t     ft_next;

    // Result register.
    logic      out_valid_reg;
    status_t   status_reg;
    slot_t     out_slot_reg;
    gen_t      out_gen_reg;
    slot_t     live_reg;

    logic      accept;
    logic      s2_fire;
    slot_t     pick_now;
    slot_t     rd_addr;
    gen_t      rd_data;
    gen_t      cur_gen;
    gen_t      bump_raw;
    gen_t      bumped;
    logic      wr_en;
    slot_t     wr_addr;
    gen_t      wr_data;
    status_t   res_status;
    slot_t     res_slot;
    gen_t      res_gen;
    slot_t     live_next;

    // The execute stage moves when the result register is empty or drains
    // in this cycle; a new request enters when the execute stage frees up.
    assign s2_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_fire;
    assign accept   = in_valid && in_ready;

    // The lowest free slot is found on the bitmap as it stands after the
    // request now executing, so back-to-back allocations see each other.
    assign pick_now = lowest_set(free_next);
    assign rd_addr  = (func == FN_ALLOC) ? pick_now : slot;

    gsa_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // A write landing on the slot being read in the same cycle is forwarded.
    assign cur_gen  = byp_reg ? byp_data_reg : rd_data;

    // Generation bump on free; the all-ones value wraps around to one.
    assign bump_raw = cur_gen + GEN_ONE;
    assign bumped   = (bump_raw == GEN_MAX) ? GEN_ONE : bump_raw;

    always_comb
    begin
        free_next  = free_reg;
        hw_next    = hw_reg;
        ft_next    = ft_reg;
        wr_en      = 1'b0;
        wr_addr    = slot_reg;
        wr_data    = GEN_ONE;
        res_status = ST_OK;
        res_slot   = slot_reg;
        res_gen    = cur_gen;
        if (func_reg == FN_ALLOC)
        begin
            if (ft_reg != '0)
            begin
                // Reuse the lowest freed slot with its stored generation.
                res_slot = pick_reg;
                if (s2_fire)
                begin
                    free_next[pick_reg] = 1'b0;
                    ft_next             = ft_reg - slot_t'(1);
                end
            end
            else if (hw_reg < hw_t'(SLOTS))
            begin
                // Take the next never-used slot at generation one.
                res_slot = hw_reg[SLOT_W-1:0];
                res_gen  = GEN_ONE;
                if (s2_fire)
                begin
                    wr_en   = 1'b1;
                    wr_addr = hw_reg[SLOT_W-1:0];
                    wr_data = GEN_ONE;
                    hw_next = hw_reg + hw_t'(1);
                end
            end
            else
            begin
                res_status = ST_FULL;
                res_slot   = '0;
                res_gen    = '0;
            end
        end
        else if (slot_reg == '0 || hw_t'(slot_reg) >= hw_reg)
        begin
            // Reserved slot zero or a slot that was never handed out.
            res_status = ST_RANGE;
            res_gen    = '0;
        end
        else if (gen_reg != '0 && gen_reg != cur_gen)
        begin
            res_status = ST_STALE;
        end
        else if (func_reg == FN_FREE && !free_reg[slot_reg])
        begin
            // Free a live slot; freeing an already free slot changes nothing.
            res_gen = bumped;
            if (s2_fire)
            begin
                wr_en              = 1'b1;
                wr_addr            = slot_reg;
                wr_data            = bumped;
                free_next[slot_reg] = 1'b1;
                ft_next            = ft_reg + slot_t'(1);
            end
        end
    end

    // Live slots are those handed out minus those sitting free.
    assign live_next = slot_t'(hw_next - hw_t'(1) - hw_t'(ft_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            free_reg      <= '0;
            hw_reg        <= hw_t'(1);
            ft_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            free_reg <= free_next;
            hw_reg   <= hw_next;
            ft_reg   <= ft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            slot_reg     <= slot;
            gen_reg      <= gen;
            pick_reg     <= pick_now;
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
        if (s2_fire)
        begin
            status_reg   <= res_status;
            out_slot_reg <= res_slot;
            out_gen_reg  <= res_gen;
            live_reg     <= live_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_slot   = out_slot_reg;
    assign out_gen    = out_gen_reg;
    assign live_count = live_reg;

    // The free count always matches the bitmap.
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(free_reg) == int'(ft_reg))
        else $error("free count differs from free bitmap");

    // Reserved slot zero is never marked free.
    a_slot0_free: assert property (@(posedge clk) disable iff (!rst_n)
        !free_reg[0])
        else $error("reserved slot marked free");

    // Free slots are a subset of the slots handed out so far.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_t'(ft_reg) < hw_reg)
        else $error("free count exceeds slots handed out");

    // A full report only comes when every slot is in use.
    a_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && res_status == ST_FULL) |-> (hw_reg == hw_t'(SLOTS) && ft_reg == '0))
        else $error("full reported while slots remain");

endmodule

### rtl/gsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the generational slot allocator: stimulus, idling and scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    // The package names the three defined functions only. The fourth encoding is
    // legal on the port and must behave like a lookup.
    localparam func_t FN_UNKNOWN = func_t'(3);

    localparam int HOLD_CYCLES  = 300;   // Length of the long result-side hold-off.
    localparam int RANDOM_ITEMS = 1180;
    localparam int WRAP_ROUNDS  = 100;   // Free/alloc rounds on slot 1.
    localparam int IDLE_PCT     = 19;
    localparam int PRINT_LIMIT  = 50;

    typedef struct packed {
        status_t status;
        slot_t   slot;
        gen_t    gen;
        slot_t   live;
    } result_t;

    // Scoreboard: it keeps its own copy of the slot store and turns every
    // accepted request into the one result that the block must return.
    class handle_scoreboard;
        gen_t    gen_mem[SLOTS];
        bit      free_mark[SLOTS];
        int      high_water;
        int      free_total;
        result_t expected_q[$];
        int      errors;

        function new();
            high_water = 1;
            free_total = 0;
            errors     = 0;
            foreach (free_mark[i]) begin
                free_mark[i] = 1'b0;
                gen_mem[i]   = '0;
            end
        endfunction

        function void note_request(func_t f, slot_t s, gen_t g);
            result_t r;
            gen_t    cur;
            int      pick;
            pick = 0;
            if (f == FN_ALLOC) begin
                // Reuse the lowest freed slot first, then the never-used one.
                for (int i = high_water - 1; i >= 1; i--) begin
                    if (free_mark[i]) begin
                        pick = i;
                    end
                end
                if (pick != 0) begin
                    free_mark[pick] = 1'b0;
                    free_total--;
                    r = '{ST_OK, slot_t'(pick), gen_mem[pick], '0};
                end else if (high_water < SLOTS) begin
                    gen_mem[high_water] = GEN_ONE;
                    r = '{ST_OK, slot_t'(high_water), GEN_ONE, '0};
                    high_water++;
                end else begin
                    r = '{ST_FULL, '0, '0, '0};
                end
            end else if (s == 0 || int'(s) >= high_water) begin
                r = '{ST_RANGE, s, '0, '0};
            end else begin
                cur = gen_mem[s];
                if (g != '0 && g != cur) begin
                    r = '{ST_STALE, s, cur, '0};
                end else begin
                    // A second free of a free slot leaves everything as it is.
                    if (f == FN_FREE && !free_mark[s]) begin
                        cur = cur + GEN_ONE;
                        if (cur == GEN_MAX) begin
                            cur = GEN_ONE;
                        end
                        gen_mem[s]   = cur;
                        free_mark[s] = 1'b1;
                        free_total++;
                    end
                    r = '{ST_OK, s, cur, '0};
                end
            end
            r.live = slot_t'(high_water - 1 - free_total);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                if (errors < PRINT_LIMIT) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
                end
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                if (errors < PRINT_LIMIT) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, got.status, got.slot, got.gen, got.live);
                end
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_slot", want.slot, got.slot);
            compare_field("out_gen", want.gen, got.gen);
            compare_field("live_count", want.live, got.live);
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    func_t   func;
    slot_t   slot;
    gen_t    gen;
    logic    out_valid;
    logic    out_ready;
    status_t status;
    slot_t   out_slot;
    gen_t    out_gen;
    slot_t   live_count;

    // Random idling on both sides is switched off for one stretch of the run.
    bit idle_on  = 1'b1;
    // Set by the stimulus to make the result side hold off for a long stretch.
    bit hold_req = 1'b0;

    handle_scoreboard sb = new();

    generational_slot_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .slot       (slot),
        .gen        (gen),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_slot   (out_slot),
        .out_gen    (out_gen),
        .live_count (live_count)
    );

    // 12 ns clock period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Every accepted result is checked at the rising edge where it is taken.
    // A request accepted at this same edge cannot have its result here yet,
    // since its result must first pass the execute stage and the output
    // register, so the order against the driver does not matter.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result('{status, out_slot, out_gen, live_count});
        end
    end

    // Result side: ready drops at random in about one cycle in five, and once
    // on request it stays low for a long stretch so that the pipeline fills
    // and the block has to push back on the request side.
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Present one request and wait for it to be taken. Inputs change at the
    // falling edge only. Valid stays high from one request to the next when
    // no gap is drawn. The scoreboard hears of the request at the edge that
    // accepts it, so the next random choice already sees its effect.
    task automatic send_request(func_t f, slot_t s, gen_t g);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func     = f;
        slot     = s;
        gen      = g;
        do @(posedge clk); while (!in_ready);
        sb.note_request(f, s, g);
    endtask

    // One random request. While growing, allocation dominates so that the
    // store runs full; while shrinking, frees of live handles dominate. A
    // tenth of the requests are noise with every field drawn at random.
    task automatic send_random(bit growing);
        int    roll;
        int    tries;
        func_t f;
        slot_t s;
        gen_t  g;
        roll = $urandom_range(99);
        if (roll < 10) begin
            f = func_t'($urandom_range(3));
            s = slot_t'($urandom_range(255));
            g = gen_t'($urandom_range(65535));
        end else begin
            roll = $urandom_range(99);
            if (roll < (growing ? 55 : 15)) begin
                f = FN_ALLOC;
            end else if (roll < 70) begin
                f = FN_FREE;
            end else begin
                f = FN_LOOKUP;
            end
            s = (sb.high_water > 1) ? slot_t'($urandom_range(sb.high_water - 1, 1)) : slot_t'(1);
            // Frees look for a live slot for a few tries, so that the store
            // really drains; the rest land on freed slots as double frees.
            tries = 0;
            while (f == FN_FREE && sb.high_water > 1 && sb.free_mark[s] && tries < 8) begin
                s = slot_t'($urandom_range(sb.high_water - 1, 1));
                tries++;
            end
            roll = $urandom_range(99);
            if (int'(s) >= sb.high_water) begin
                g = '0;
            end else if (roll < 60) begin
                g = sb.gen_mem[s];
            end else if (roll < 80) begin
                g = '0;
            end else begin
                g = gen_t'($urandom_range(65535));
            end
        end
        send_request(f, s, g);
    endtask

    // Main sequence: reset, directed requests, free and reuse rounds on one
    // slot, then the random part with a hold-off and a stretch without idling.
    initial
    begin
        bit growing;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FN_ALLOC;
        slot     = '0;
        gen      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reserved slot and a slot that was never handed out.
        send_request(FN_LOOKUP, slot_t'(0), gen_t'(0));
        send_request(FN_FREE, slot_t'(255), GEN_MAX);
        // First allocations take fresh slots at generation one; the slot and
        // generation fields are ignored here.
        send_request(FN_ALLOC, slot_t'(255), GEN_MAX);
        send_request(FN_ALLOC, slot_t'(0), gen_t'(0));
        // Lookups: exact generation, wildcard, stale.
        send_request(FN_LOOKUP, slot_t'(1), GEN_ONE);
        send_request(FN_LOOKUP, slot_t'(1), gen_t'(0));
        send_request(FN_LOOKUP, slot_t'(1), GEN_MAX);
        // A stale free, a good one, then a double free.
        send_request(FN_FREE, slot_t'(1), gen_t'(2));
        send_request(FN_FREE, slot_t'(1), GEN_ONE);
        send_request(FN_FREE, slot_t'(1), gen_t'(0));
        // A freed slot still answers a lookup with its new generation.
        send_request(FN_LOOKUP, slot_t'(1), gen_t'(2));
        // The undefined function code acts as a lookup.
        send_request(FN_UNKNOWN, slot_t'(2), GEN_ONE);
        send_request(FN_UNKNOWN, slot_t'(0), gen_t'(0));
        send_request(FN_LOOKUP, slot_t'(3), GEN_ONE);
        send_request(FN_FREE, slot_t'(0), gen_t'(0));
        // Reuse of the freed slot keeps its bumped generation.
        send_request(FN_ALLOC, slot_t'(0), gen_t'(0));
        send_request(FN_LOOKUP, slot_t'(2), gen_t'(16'h5555));
        send_request(FN_LOOKUP, slot_t'(2), gen_t'(16'hAAAA));

        // Slot 1 is the only slot ever freed here, so each allocation takes
        // it back and its generation climbs by one every round.
        for (int n = 0; n < WRAP_ROUNDS; n++) begin
            send_request(FN_FREE, slot_t'(1), n[0] ? sb.gen_mem[1] : gen_t'(0));
            send_request(FN_ALLOC, slot_t'($urandom_range(255)),
                         gen_t'($urandom_range(65535)));
        end

        growing = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) begin
                hold_req = 1'b1;
            end
            idle_on = !(n >= 600 && n < 900);
            if (growing && sb.high_water == SLOTS && sb.free_total == 0
                && $urandom_range(9) == 0) begin
                growing = 1'b0;
            end else if (!growing && (sb.high_water - 1 - sb.free_total) < 16) begin
                growing = 1'b1;
            end
            send_random(growing);
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog, set far beyond the slowest expected run.
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
